FILE: hw/rtl/qi8p_pkg.sv
package qi8p_pkg;

   localparam int FRAC_W   = 24;   // fraction bits of log2 value and exponent
   localparam int MANT_W   = 31;   // Q1.30 mantissa
   localparam int XW       = 40;   // affine base / exponent width
   localparam int STEPS    = 24;   // squaring steps and root steps
   localparam int Q_W      = 11;   // capped magnitude width
   localparam int SAT_CAP  = 1024;

   localparam logic [2:0] CSR_BASE_GAIN      = 3'd0;
   localparam logic [2:0] CSR_BASE_OFFSET    = 3'd1;
   localparam logic [2:0] CSR_EXP_GAIN       = 3'd2;
   localparam logic [2:0] CSR_EXP_OFFSET     = 3'd3;
   localparam logic [2:0] CSR_OUT_INV_SCALE  = 3'd4;
   localparam logic [2:0] CSR_OUT_ZERO_POINT = 3'd5;
   localparam logic [2:0] CSR_ACT_MIN        = 3'd6;
   localparam logic [2:0] CSR_ACT_MAX        = 3'd7;

   typedef struct packed {
      logic signed [7:0] base_code;
      logic signed [7:0] exp_code;
      logic              last_element;
   } req_type;

   typedef struct packed {
      logic signed [7:0] result_code;
      logic              domain_error;
      logic              last_out;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] base_gain;
      logic signed [31:0] base_offset;
      logic signed [31:0] exp_gain;
      logic signed [31:0] exp_offset;
      logic        [31:0] out_inv_scale;
      logic signed [7:0]  out_zero_point;
      logic signed [7:0]  act_min;
      logic signed [7:0]  act_max;
   } cfg_type;

   typedef struct packed {
      logic dom;
      logic neg;
      logic zero_x;
      logic zero_e;
      logic last;
   } flag_type;

   typedef struct packed {
      flag_type                flag;
      logic [MANT_W-1:0]       m;
      logic [FRAC_W-1:0]       frac;
      logic [5:0]              p;
      logic signed [XW-1:0]    e;
   } log_type;

   typedef struct packed {
      flag_type                flag;
      logic [MANT_W-1:0]       m;
      logic signed [23:0]      n;
      logic [FRAC_W-1:0]       f;
   } root_type;

   function automatic logic [63:0] isqrt64(input logic [63:0] v);
      logic [63:0] res;
      logic [63:0] rem;
      logic [63:0] bit_w;
      res   = '0;
      rem   = v;
      bit_w = 64'h4000_0000_0000_0000;
      for (int i = 0; i < 32; i++) begin
         if (rem >= res + bit_w) begin
            rem = rem - (res + bit_w);
            res = (res >> 1) + bit_w;
         end else begin
            res = res >> 1;
         end
         bit_w = bit_w >> 2;
      end
      return res;
   endfunction

   // 2^30 * 2^(2^-k), truncated through repeated square roots
   function automatic logic [31:0] root_entry(input int k);
      logic [63:0] r;
      r = 64'h8000_0000;
      for (int j = 1; j <= k; j++) begin
         r = isqrt64(r << 30);
      end
      return r[31:0];
   endfunction

endpackage

FILE: hw/rtl/qi8p_front.sv
module qi8p_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              req_valid,
   input  qi8p_pkg::req_type req_data,
   input  qi8p_pkg::cfg_type cfg,
   output logic              dout_valid,
   output qi8p_pkg::log_type dout
);
   import qi8p_pkg::*;

   logic [3:0]           vld_ff;
   logic signed [XW-1:0] px_ff, pe_ff, px_in, pe_in;
   logic                 last1_ff, last2_ff;
   logic signed [XW-1:0] x_ff, e_ff, x_in, e_in;
   logic [XW-1:0]        ax_ff, ax_in;
   logic signed [XW-1:0] e3_ff;
   flag_type             flag_ff, flag_in;
   log_type              out_ff, out_in;

   assign px_in = XW'(cfg.base_gain) * XW'(req_data.base_code);
   assign pe_in = XW'(cfg.exp_gain) * XW'(req_data.exp_code);
   assign x_in  = px_ff + XW'(cfg.base_offset);
   assign e_in  = pe_ff + XW'(cfg.exp_offset);

   always_comb begin
      ax_in          = x_ff[XW-1] ? XW'(-x_ff) : XW'(x_ff);
      flag_in.zero_x = (x_ff == '0);
      flag_in.zero_e = (e_ff == '0);
      flag_in.neg    = x_ff[XW-1] & e_ff[FRAC_W];
      flag_in.dom    = (x_ff[XW-1] && (e_ff[FRAC_W-1:0] != '0)) ||
                       ((x_ff == '0) && e_ff[XW-1]);
      flag_in.last   = last2_ff;
   end

   // find the top set bit and move it to the mantissa's leading place
   always_comb begin
      logic [5:0]    p;
      logic [XW-1:0] norm;
      p = '0;
      for (int i = 0; i < XW; i++) begin
         if (ax_ff[i]) p = 6'(i);
      end
      norm        = ax_ff << (6'(XW - 1) - p);
      out_in.flag = flag_ff;
      out_in.m    = norm[XW-1:XW-MANT_W];
      out_in.frac = '0;
      out_in.p    = p;
      out_in.e    = e3_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[2:0], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         px_ff    <= px_in;
         pe_ff    <= pe_in;
         last1_ff <= req_data.last_element;
         x_ff     <= x_in;
         e_ff     <= e_in;
         last2_ff <= last1_ff;
         ax_ff    <= ax_in;
         e3_ff    <= e_ff;
         flag_ff  <= flag_in;
         out_ff   <= out_in;
      end
   end

   assign dout_valid = vld_ff[3];
   assign dout       = out_ff;

endmodule

FILE: hw/rtl/qi8p_log2.sv
module qi8p_log2 (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              din_valid,
   input  qi8p_pkg::log_type din,
   output logic              dout_valid,
   output qi8p_pkg::log_type dout
);
   import qi8p_pkg::*;

   logic    vld_ff [0:STEPS-1];
   log_type st_ff  [0:STEPS-1];

   for (genvar k = 0; k < STEPS; k++) begin : g_step
      log_type     cur;
      log_type     st_in;
      logic        vin;
      logic [61:0] sq;
      logic [31:0] sh;

      if (k == 0) begin : g_first
         assign cur = din;
         assign vin = din_valid;
      end else begin : g_next
         assign cur = st_ff[k-1];
         assign vin = vld_ff[k-1];
      end

      // square, then renormalise and take one fraction bit
      always_comb begin
         sq    = 62'(cur.m) * 62'(cur.m);
         sh    = sq[61:30];
         st_in = cur;
         if (sh[31]) begin
            st_in.m    = sh[31:1];
            st_in.frac = {cur.frac[FRAC_W-2:0], 1'b1};
         end else begin
            st_in.m    = sh[30:0];
            st_in.frac = {cur.frac[FRAC_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (adv) begin
            vld_ff[k] <= vin;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            st_ff[k] <= st_in;
         end
      end
   end

   assign dout_valid = vld_ff[STEPS-1];
   assign dout       = st_ff[STEPS-1];

endmodule

FILE: hw/rtl/qi8p_exp2.sv
module qi8p_exp2 (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  logic               din_valid,
   input  qi8p_pkg::log_type  din,
   output logic               dout_valid,
   output qi8p_pkg::root_type dout
);
   import qi8p_pkg::*;

   logic [3:0]         pv_ff;
   flag_type           f1_ff, f2_ff, f3_ff;
   logic [28:0]        ul_ff, ul_in;
   logic [15:0]        hi_ff, hi_in;
   logic [23:0]        lo_ff, lo_in;
   logic               sg1_ff, sg2_ff, sg3_ff, sg_in;
   logic [44:0]        phi_ff, phi_in;
   logic [52:0]        plo_ff, plo_in;
   logic [45:0]        mag_ff, mag_in;
   root_type           y_ff, y_in;
   logic               vld_ff [0:STEPS-1];
   root_type           st_ff  [0:STEPS-1];

   // log2 value times exponent, split in whole and fraction parts of the exponent
   always_comb begin
      logic signed [29:0] lval;
      logic [XW-1:0]      ue;
      lval  = $signed({6'(din.p - 6'd16), din.frac});
      ul_in = lval[29] ? 29'(-lval) : 29'(lval);
      ue    = din.e[XW-1] ? XW'(-din.e) : XW'(din.e);
      hi_in = ue[XW-1:FRAC_W];
      lo_in = ue[FRAC_W-1:0];
      sg_in = lval[29] ^ din.e[XW-1];
   end

   assign phi_in = 45'(ul_ff) * 45'(hi_ff);
   assign plo_in = 53'(ul_ff) * 53'(lo_ff);
   assign mag_in = 46'(phi_ff) + 46'(plo_ff[52:FRAC_W]);

   always_comb begin
      logic signed [47:0] y;
      y         = sg3_ff ? -$signed(48'(mag_ff)) : $signed(48'(mag_ff));
      y_in.flag = f3_ff;
      y_in.m    = MANT_W'(1) << 30;
      y_in.n    = y[47:FRAC_W];
      y_in.f    = y[FRAC_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff <= '0;
      end else if (adv) begin
         pv_ff <= {pv_ff[2:0], din_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ul_ff  <= ul_in;
         hi_ff  <= hi_in;
         lo_ff  <= lo_in;
         sg1_ff <= sg_in;
         f1_ff  <= din.flag;
         phi_ff <= phi_in;
         plo_ff <= plo_in;
         sg2_ff <= sg1_ff;
         f2_ff  <= f1_ff;
         mag_ff <= mag_in;
         sg3_ff <= sg2_ff;
         f3_ff  <= f2_ff;
         y_ff   <= y_in;
      end
   end

   for (genvar k = 0; k < STEPS; k++) begin : g_root
      localparam logic [31:0] ROOT_K = root_entry(k + 1);
      root_type    cur;
      root_type    st_in;
      logic        vin;
      logic [61:0] prod;

      if (k == 0) begin : g_first
         assign cur = y_ff;
         assign vin = pv_ff[3];
      end else begin : g_next
         assign cur = st_ff[k-1];
         assign vin = vld_ff[k-1];
      end

      always_comb begin
         prod  = 62'(cur.m) * 62'(ROOT_K);
         st_in = cur;
         if (cur.f[FRAC_W-1-k]) begin
            st_in.m = prod[60:30];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (adv) begin
            vld_ff[k] <= vin;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            st_ff[k] <= st_in;
         end
      end
   end

   assign dout_valid = vld_ff[STEPS-1];
   assign dout       = st_ff[STEPS-1];

endmodule

FILE: hw/rtl/qi8p_scale.sv
module qi8p_scale (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  logic               din_valid,
   input  qi8p_pkg::root_type din,
   input  qi8p_pkg::cfg_type  cfg,
   output logic               dout_valid,
   output qi8p_pkg::rsp_type  dout
);
   import qi8p_pkg::*;

   logic [2:0]         vld_ff;
   logic [62:0]        t_ff, t_in;
   logic signed [23:0] n_ff, n_in;
   flag_type           f1_ff, f2_ff;
   logic [Q_W-1:0]     q_ff, q_in;
   rsp_type            out_ff, out_in;

   // a zero base takes the path of 2^0 so that zero to the zero gives one
   always_comb begin
      logic [MANT_W-1:0] msel;
      msel = din.flag.zero_x ? (MANT_W'(1) << 30) : din.m;
      n_in = din.flag.zero_x ? '0 : din.n;
      t_in = 63'(msel) * 63'(cfg.out_inv_scale);
   end

   always_comb begin
      logic signed [24:0] sh;
      logic [5:0]         sh_lo;
      logic [5:0]         sh_m1;
      logic [63:0]        sum;
      logic [63:0]        qf;
      sh    = 25'sd46 - 25'(n_ff);
      sh_lo = sh[5:0];
      sh_m1 = sh_lo - 6'd1;
      sum   = 64'(t_ff) + (64'd1 << sh_m1);
      qf    = sum >> sh_lo;
      priority if (t_ff == '0 || (f1_ff.zero_x && !f1_ff.zero_e)) begin
         q_in = '0;
      end else if (sh <= 25'sd0) begin
         q_in = Q_W'(SAT_CAP);
      end else if (sh >= 25'sd64) begin
         q_in = '0;
      end else if (qf > 64'(SAT_CAP)) begin
         q_in = Q_W'(SAT_CAP);
      end else begin
         q_in = qf[Q_W-1:0];
      end
   end

   always_comb begin
      logic signed [12:0] qs;
      logic signed [12:0] v;
      logic signed [12:0] r;
      qs = $signed(13'(q_ff));
      if (f2_ff.dom) begin
         v = 13'(cfg.out_zero_point);
      end else if (f2_ff.neg) begin
         v = 13'(cfg.out_zero_point) - qs;
      end else begin
         v = 13'(cfg.out_zero_point) + qs;
      end
      r = (v < 13'(cfg.act_max)) ? v : 13'(cfg.act_max);
      r = (r > 13'(cfg.act_min)) ? r : 13'(cfg.act_min);
      out_in.result_code  = r[7:0];
      out_in.domain_error = f2_ff.dom;
      out_in.last_out     = f2_ff.last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[1:0], din_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         t_ff   <= t_in;
         n_ff   <= n_in;
         f1_ff  <= din.flag;
         q_ff   <= q_in;
         f2_ff  <= f1_ff;
         out_ff <= out_in;
      end
   end

   assign dout_valid = vld_ff[2];
   assign dout       = out_ff;

endmodule

FILE: hw/rtl/quantized_int8_power.sv
// Channel  Direction  Handshake             Payload
// req      in         req_valid/req_ready   req_data  (base_code, exp_code, last_element)
// rsp      out        rsp_valid/rsp_ready   rsp_data  (result_code, domain_error, last_out)
// csr      in         csr_we                csr_index, csr_wdata
//
// One transaction per cycle while no result is held at the output; each result passes through
// the 24 squaring stages of log2, the 24 root stages of exp2 and the affine,
// product and scaling stages around them.
// Synchronous reset clears the valid bits and loads the register defaults.
// A result held at the output freezes the whole pipeline; nothing is dropped or repeated.
module quantized_int8_power (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  qi8p_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output qi8p_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic [2:0]        csr_index,
   input  logic [31:0]       csr_wdata
);
   import qi8p_pkg::*;

   cfg_type  cfg_ff;
   logic     adv;
   logic     lg_in_valid, ex_in_valid, sc_in_valid;
   log_type  lg_in, ex_in;
   root_type sc_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.base_gain      <= 32'sd65536;
         cfg_ff.base_offset    <= '0;
         cfg_ff.exp_gain       <= '0;
         cfg_ff.exp_offset     <= 32'sd16777216;
         cfg_ff.out_inv_scale  <= 32'd65536;
         cfg_ff.out_zero_point <= '0;
         cfg_ff.act_min        <= -8'sd128;
         cfg_ff.act_max        <= 8'sd127;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_BASE_GAIN:      cfg_ff.base_gain      <= csr_wdata;
            CSR_BASE_OFFSET:    cfg_ff.base_offset    <= csr_wdata;
            CSR_EXP_GAIN:       cfg_ff.exp_gain       <= csr_wdata;
            CSR_EXP_OFFSET:     cfg_ff.exp_offset     <= csr_wdata;
            CSR_OUT_INV_SCALE:  cfg_ff.out_inv_scale  <= csr_wdata;
            CSR_OUT_ZERO_POINT: cfg_ff.out_zero_point <= csr_wdata[7:0];
            CSR_ACT_MIN:        cfg_ff.act_min        <= csr_wdata[7:0];
            CSR_ACT_MAX:        cfg_ff.act_max        <= csr_wdata[7:0];
            default:            cfg_ff.act_max        <= cfg_ff.act_max;
         endcase
      end
   end

   // advance everything unless a finished transaction waits at the output
   assign adv       = !rsp_valid || rsp_ready;
   assign req_ready = adv;

   qi8p_front u_front (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .req_valid  (req_valid),
      .req_data   (req_data),
      .cfg        (cfg_ff),
      .dout_valid (lg_in_valid),
      .dout       (lg_in)
   );

   qi8p_log2 u_log2 (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .din_valid  (lg_in_valid),
      .din        (lg_in),
      .dout_valid (ex_in_valid),
      .dout       (ex_in)
   );

   qi8p_exp2 u_exp2 (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .din_valid  (ex_in_valid),
      .din        (ex_in),
      .dout_valid (sc_in_valid),
      .dout       (sc_in)
   );

   qi8p_scale u_scale (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .din_valid  (sc_in_valid),
      .din        (sc_in),
      .cfg        (cfg_ff),
      .dout_valid (rsp_valid),
      .dout       (rsp_data)
   );

`ifndef SYNTHESIS
   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !req_ready)
      else $error("input taken while output is stalled");

   a_empty_output_takes_input: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input refused with an empty output register");

   a_reset_clears_output: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("output valid right after reset");
`endif

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps

import qi8p_pkg::*;

class pow_scoreboard;
   rsp_type pending_q[$];
   int      errors;
   int      checked;
   int      dom_seen;
   int      sat_seen;

   logic signed [31:0] g_base, o_base, g_exp, o_exp;
   logic        [31:0] inv_scale;
   logic signed [7:0]  zero_pt, lo_clamp, hi_clamp;
   logic        [63:0] roots[25];

   function new();
      errors   = 0;
      checked  = 0;
      dom_seen = 0;
      sat_seen = 0;
      roots[0] = 64'h8000_0000;
      for (int k = 1; k <= 24; k++) roots[k] = int_sqrt(roots[k-1] << 30);
      set_defaults();
   endfunction

   function void set_defaults();
      g_base = 32'sd65536; o_base = '0; g_exp = '0; o_exp = 32'sd16777216;
      inv_scale = 32'd65536; zero_pt = '0; lo_clamp = -8'sd128; hi_clamp = 8'sd127;
   endfunction

   static function logic [63:0] int_sqrt(logic [63:0] v);
      logic [63:0] res, b;
      res = 0;
      b   = 64'h4000_0000_0000_0000;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v   = v - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   function void write_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
         CSR_BASE_GAIN:      g_base = val;
         CSR_BASE_OFFSET:    o_base = val;
         CSR_EXP_GAIN:       g_exp = val;
         CSR_EXP_OFFSET:     o_exp = val;
         CSR_OUT_INV_SCALE:  inv_scale = val;
         CSR_OUT_ZERO_POINT: zero_pt = val[7:0];
         CSR_ACT_MIN:        lo_clamp = val[7:0];
         CSR_ACT_MAX:        hi_clamp = val[7:0];
         default: ;
      endcase
   endfunction

   function logic [63:0] scaled_mag(logic [63:0] m, longint n);
      logic [63:0] t, q;
      longint sh;
      t  = m * {32'd0, inv_scale};
      sh = 46 - n;
      if (t == 0) return 0;
      if (sh <= 0) return 1024;
      if (sh >= 64) return 0;
      q = (t + (64'd1 << (sh - 1))) >> sh;
      return (q > 1024) ? 64'd1024 : q;
   endfunction

   function logic [63:0] power_mag(logic [63:0] ax, longint e);
      int p;
      logic [63:0] m, frac, ul, ue, mag, fb;
      longint l, y, n, f;
      p = 63;
      while (ax[p] == 1'b0) p--;
      m    = (p > 30) ? (ax >> (p - 30)) : (ax << (30 - p));
      frac = 0;
      for (int i = 0; i < 24; i++) begin
         m    = (m * m) >> 30;
         frac = frac << 1;
         if (m >= (64'd1 << 31)) begin
            m    = m >> 1;
            frac = frac | 1;
         end
      end
      l   = longint'(p - 16) * (longint'(1) << 24) + longint'(frac);
      ul  = (l < 0) ? -l : l;
      ue  = (e < 0) ? -e : e;
      mag = ul * (ue >> 24) + ((ul * (ue & 64'hFF_FFFF)) >> 24);
      y   = ((l < 0) != (e < 0)) ? -longint'(mag) : longint'(mag);
      if (y >= 0) n = y >>> 24;
      else n = -longint'((64'(-y) + 64'hFF_FFFF) >> 24);
      f  = y - n * (longint'(1) << 24);
      fb = f;
      m  = 64'd1 << 30;
      for (int i = 1; i <= 24; i++)
         if (fb[24 - i]) m = (m * roots[i]) >> 30;
      return scaled_mag(m, n);
   endfunction

   function void note_request(req_type r);
      rsp_type exp_rsp;
      longint x, e, v, res;
      logic [63:0] q, eb;
      logic dom, neg;
      x   = longint'(g_base) * longint'(r.base_code) + longint'(o_base);
      e   = longint'(g_exp) * longint'(r.exp_code) + longint'(o_exp);
      eb  = e;
      dom = (x < 0 && eb[23:0] != 0) || (x == 0 && e < 0);
      v   = zero_pt;
      if (!dom) begin
         neg = 0;
         if (x == 0) q = (e == 0) ? scaled_mag(64'd1 << 30, 0) : 0;
         else begin
            q   = power_mag((x < 0) ? -x : x, e);
            neg = (x < 0) && eb[24];
         end
         if (q == 1024) sat_seen++;
         v = v + (neg ? -longint'(q) : longint'(q));
      end else begin
         dom_seen++;
      end
      res = (v < hi_clamp) ? v : hi_clamp;
      res = (res > lo_clamp) ? res : lo_clamp;
      exp_rsp.result_code  = res[7:0];
      exp_rsp.domain_error = dom;
      exp_rsp.last_out     = r.last_element;
      pending_q.push_back(exp_rsp);
   endfunction

   function void check_result(rsp_type got);
      rsp_type want;
      if (pending_q.size() == 0) begin
         $display("%0t: unexpected result %p", $time, got);
         errors++;
         return;
      end
      want = pending_q.pop_front();
      checked++;
      if (got.result_code !== want.result_code) begin
         $display("%0t: result_code expected %0d actual %0d", $time,
                  want.result_code, got.result_code);
         errors++;
      end
      if (got.domain_error !== want.domain_error) begin
         $display("%0t: domain_error expected %0b actual %0b", $time,
                  want.domain_error, got.domain_error);
         errors++;
      end
      if (got.last_out !== want.last_out) begin
         $display("%0t: last_out expected %0b actual %0b", $time,
                  want.last_out, got.last_out);
         errors++;
      end
   endfunction
endclass

module testbench;
   logic    clock = 0;
   logic    reset = 1;
   logic    req_valid = 0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 0;
   rsp_type rsp_data;
   logic    csr_we = 0;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_wdata = '0;

   pow_scoreboard sb;
   int  idle_cycles;
   int  sent;
   bit  hold_off;

   quantized_int8_power dut (.*);

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   // watchdog: count cycles with no transaction on either channel
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
         $display("watchdog expired at %0t", $time);
         $display("** quantized_int8_power: FAILED **");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (rsp_valid && rsp_ready) sb.check_result(rsp_data);
   end

   // receiver: random stalls, plus one long hold-off on request
   initial begin
      int gap;
      @(negedge reset);
      forever begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
         if (hold_off) begin
            rsp_ready <= 0;
            repeat (300) @(posedge clock);
            hold_off = 0;
         end
         if ($urandom_range(0, 1) == 0) gap = 0;
         repeat (gap) begin
            rsp_ready <= 0;
            @(posedge clock);
         end
         rsp_ready <= 1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   task automatic send_item(logic signed [7:0] b, logic signed [7:0] ec, bit burst);
      int gap;
      gap = burst ? 0 : $urandom_range(0, 16);
      if (gap != 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid             <= 1;
      req_data.base_code    <= b;
      req_data.exp_code     <= ec;
      req_data.last_element <= 1'($urandom_range(0, 1));
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_request(req_data);
      sent++;
   endtask

   task automatic drain();
      req_valid <= 0;
      while (sb.pending_q.size() != 0) @(posedge clock);
      repeat (70) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [31:0] val);
      csr_we    <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 0;
      sb.write_reg(idx, val);
      @(posedge clock);
   endtask

   task automatic random_config();
      int sel;
      sel = $urandom_range(0, 5);
      write_reg(CSR_BASE_GAIN, (sel == 0) ? 32'h8000_0000 :
                (sel == 1) ? 32'h7FFF_FFFF : $urandom_range(1024, 262144) *
                ($urandom_range(0, 1) ? 1 : -1));
      write_reg(CSR_BASE_OFFSET, (sel == 2) ? $urandom : $urandom_range(0, 524288) - 262144);
      case ($urandom_range(0, 3))
         0: write_reg(CSR_EXP_GAIN, 0);
         1: write_reg(CSR_EXP_GAIN, $urandom_range(0, 8) << 21);
         2: write_reg(CSR_EXP_GAIN, 32'sd1 <<< 24);
         default: write_reg(CSR_EXP_GAIN, (sel == 3) ? $urandom : $urandom_range(0, 1 << 22));
      endcase
      write_reg(CSR_EXP_OFFSET, $urandom_range(0, 1) ?
                (($urandom_range(0, 6) - 2) << 24) : $urandom_range(0, 1 << 26) - (1 << 25));
      write_reg(CSR_OUT_INV_SCALE, (sel == 4) ? 32'hFFFF_FFFF :
                (sel == 5) ? 32'd0 : $urandom_range(1 << 12, 1 << 20));
      write_reg(CSR_OUT_ZERO_POINT, $urandom);
      write_reg(CSR_ACT_MIN, ($urandom_range(0, 7) == 0) ? $urandom : -128 + $urandom_range(0, 20));
      write_reg(CSR_ACT_MAX, ($urandom_range(0, 7) == 0) ? $urandom : 127 - $urandom_range(0, 20));
   endtask

   initial begin
      sb        = new();
      sent      = 0;
      hold_off  = 0;
      idle_cycles = 0;
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // defaults: identity power over the extremes
      send_item(-128, 0, 0);
      send_item(127, 0, 0);
      send_item(0, 0, 0);
      send_item(-1, 5, 0);
      send_item(1, -128, 0);
      drain();
      // square, cube, negative base with odd/even power, zero base cases
      write_reg(CSR_EXP_GAIN, 32'sd1 <<< 24);
      write_reg(CSR_EXP_OFFSET, 0);
      send_item(-3, 3, 0);
      send_item(-3, 2, 0);
      send_item(0, 0, 0);
      send_item(0, 2, 0);
      send_item(0, -1, 0);
      send_item(127, 127, 0);
      send_item(-128, 127, 0);
      send_item(-128, -128, 0);
      drain();
      // half power: negative base is a domain error, crossed clamp bounds
      write_reg(CSR_EXP_GAIN, 0);
      write_reg(CSR_EXP_OFFSET, 32'sd1 <<< 23);
      write_reg(CSR_OUT_ZERO_POINT, 8'sd100);
      write_reg(CSR_ACT_MIN, 8'sd10);
      write_reg(CSR_ACT_MAX, -8'sd10);
      write_reg(CSR_OUT_INV_SCALE, 32'hFFFF_FFFF);
      send_item(-4, 0, 0);
      send_item(4, 0, 0);
      send_item(0, 0, 0);
      drain();
      write_reg(CSR_ACT_MIN, -8'sd128);
      write_reg(CSR_ACT_MAX, 8'sd127);
      write_reg(CSR_OUT_ZERO_POINT, -8'sd128);
      send_item(100, 0, 0);
      send_item(-5, 0, 0);
      drain();

      // random phases; one longer phase fills the pipeline against a stalled receiver
      for (int ph = 0; ph < 30; ph++) begin
         random_config();
         if (ph == 3) hold_off = 1;
         for (int i = 0; i < ((ph == 3) ? 100 : 50); i++)
            send_item(8'($urandom), 8'($urandom), (ph == 3) || ($urandom_range(0, 4) == 0));
         drain();
      end
      $display("%0d items sent, %0d results checked, %0d domain errors, %0d saturated",
               sent, sb.checked, sb.dom_seen, sb.sat_seen);
      if (sb.errors == 0) $display("** quantized_int8_power: PASSED **");
      else $display("** quantized_int8_power: FAILED **");
      $finish;
   end
endmodule

FILE: quantized_int8_power.f
hw/rtl/qi8p_pkg.sv
hw/rtl/qi8p_front.sv
hw/rtl/qi8p_log2.sv
hw/rtl/qi8p_exp2.sv
hw/rtl/qi8p_scale.sv
hw/rtl/quantized_int8_power.sv
tb/sv/testbench.sv
